>>> hw/rtl/tilt_prioritized_attitude_rates_top_macros.svh
// Assertion macros shared by the checker of the attitude rate block.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef TILT_PRIORITIZED_ATTITUDE_RATES_TOP_MACROS_SVH
`define TILT_PRIORITIZED_ATTITUDE_RATES_TOP_MACROS_SVH

// Implication that is checked in the same cycle.
`define TPAR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Plain invariant.
`define TPAR_ASSERT_ALW(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/tpar_pkg.sv
// Shared types and constants of the attitude rate block.
// Depends on nothing; imported by every RTL module of the block.
package tpar_pkg;

    localparam int QW      = 16;   // quaternion component width
    localparam int EW      = 20;   // rounded error component width
    localparam int D2W     = 38;   // width of ew^2 + ez^2
    localparam int DW      = 19;   // width of its square root
    localparam int MAGW    = 38;   // magnitude of a raw rate
    localparam int GW      = 16;   // gain width
    localparam int NUMW    = 55;   // 2 * gain * magnitude
    localparam int DENW    = 29;   // d * 1024
    localparam int RW      = 24;   // rate width
    localparam int LATENCY = 50;   // accept to result strobe, in cycles

    localparam logic [1:0] REG_GAIN_TILT = 2'd0;
    localparam logic [1:0] REG_GAIN_YAW  = 2'd1;

    typedef struct packed {
        logic [2:0]      neg;
        logic [MAGW-1:0] mag_x;
        logic [MAGW-1:0] mag_y;
        logic [MAGW-1:0] mag_z;
    } t_raw;

    typedef struct packed {
        logic            neg;
        logic            zero;
        logic [NUMW-1:0] num;
        logic [DENW-1:0] den;
    } t_div_req;

endpackage

>>> hw/rtl/tilt_prioritized_attitude_rates_top.sv
// Tilt-prioritized attitude rate law: each accepted start yields one result under o_valid.
// Throughput one beat per cycle while busy is low; busy is set only by reset.
// Depth: front, 19-stage square root, scaling, divider lanes with 24 quotient stages.
// Reset (synchronous, active low) clears the gains to zero and drops all beats in flight.
// Results are shown for one cycle under o_valid; the receiver cannot stall.
// Depends on tpar_pkg, tpar_front, tpar_sqrt and tpar_div.
module tilt_prioritized_attitude_rates_top import tpar_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [QW-1:0] i_meas_w,
    input  logic signed [QW-1:0] i_meas_x,
    input  logic signed [QW-1:0] i_meas_y,
    input  logic signed [QW-1:0] i_meas_z,
    input  logic signed [QW-1:0] i_goal_w,
    input  logic signed [QW-1:0] i_goal_x,
    input  logic signed [QW-1:0] i_goal_y,
    input  logic signed [QW-1:0] i_goal_z,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [GW-1:0]        i_cfg_wdata,
    output logic                 o_valid,
    output logic signed [RW-1:0] o_rate_roll,
    output logic signed [RW-1:0] o_rate_pitch,
    output logic signed [RW-1:0] o_rate_yaw,
    output logic                 o_undefined_flag
);

    logic [GW-1:0]         r_gain_tilt, r_gain_yaw;
    logic                  r_busy;
    logic                  accept;
    logic signed [QW-1:0]  q_vec [4];
    logic signed [QW-1:0]  g_vec [4];

    logic                  fr_vld;
    logic [D2W-1:0]        fr_d2;
    t_raw                  fr_raw;

    logic                  sq_vld;
    logic [DW-1:0]         sq_root;
    t_raw                  r_raw_dly [DW];

    logic                  r_sc_vld;
    t_div_req              r_req [3];
    logic                  dv_vld [3];
    logic [RW-1:0]         dv_rate [3];

    // The undefined flag rides alongside the divider lanes.
    logic                  r_flag_dly [RW+2];

    // Configuration writes land directly; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_tilt <= '0;
            r_gain_yaw  <= '0;
            r_busy      <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we && (i_cfg_idx == REG_GAIN_TILT)) begin
                r_gain_tilt <= i_cfg_wdata;
            end
            if (i_cfg_we && (i_cfg_idx == REG_GAIN_YAW)) begin
                r_gain_yaw <= i_cfg_wdata;
            end
        end
    end

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    assign q_vec[0] = i_meas_w;
    assign q_vec[1] = i_meas_x;
    assign q_vec[2] = i_meas_y;
    assign q_vec[3] = i_meas_z;
    assign g_vec[0] = i_goal_w;
    assign g_vec[1] = i_goal_x;
    assign g_vec[2] = i_goal_y;
    assign g_vec[3] = i_goal_z;

    tpar_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (accept),
        .i_q     (q_vec),
        .i_g     (g_vec),
        .o_vld   (fr_vld),
        .o_d2    (fr_d2),
        .o_raw   (fr_raw)
    );

    tpar_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (fr_vld),
        .i_rad   (fr_d2),
        .o_vld   (sq_vld),
        .o_root  (sq_root)
    );

    // The raw rate magnitudes wait in a shift line while the root is formed.
    always_ff @(posedge i_clk) begin
        r_raw_dly[0] <= fr_raw;
        for (int k = 1; k < DW; k++) begin
            r_raw_dly[k] <= r_raw_dly[k-1];
        end
    end

    // Scaling stage: one gain multiply per lane, denominator d * 1024.
    always_ff @(posedge i_clk) begin
        r_req[0].neg  <= r_raw_dly[DW-1].neg[0];
        r_req[1].neg  <= r_raw_dly[DW-1].neg[1];
        r_req[2].neg  <= r_raw_dly[DW-1].neg[2];
        r_req[0].num  <= {(NUMW-1)'(r_gain_tilt) * (NUMW-1)'(r_raw_dly[DW-1].mag_x), 1'b0};
        r_req[1].num  <= {(NUMW-1)'(r_gain_tilt) * (NUMW-1)'(r_raw_dly[DW-1].mag_y), 1'b0};
        r_req[2].num  <= {(NUMW-1)'(r_gain_yaw) * (NUMW-1)'(r_raw_dly[DW-1].mag_z), 1'b0};
        for (int l = 0; l < 3; l++) begin
            r_req[l].zero <= (sq_root == '0);
            r_req[l].den  <= {sq_root, 10'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_vld <= 1'b0;
        end else begin
            r_sc_vld <= sq_vld;
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        tpar_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (r_sc_vld),
            .i_req   (r_req[l]),
            .o_vld   (dv_vld[l]),
            .o_rate  (dv_rate[l])
        );
    end

    always_ff @(posedge i_clk) begin
        r_flag_dly[0] <= r_req[0].zero;
        for (int k = 1; k < RW + 2; k++) begin
            r_flag_dly[k] <= r_flag_dly[k-1];
        end
    end

    assign o_valid          = dv_vld[0] && dv_vld[1] && dv_vld[2];
    assign o_rate_roll      = dv_rate[0];
    assign o_rate_pitch     = dv_rate[1];
    assign o_rate_yaw       = dv_rate[2];
    assign o_undefined_flag = o_valid && r_flag_dly[RW+1];

endmodule

>>> hw/rtl/tpar_front.sv
// Error quaternion, the sum ew^2 + ez^2 and raw rate magnitudes, four register stages.
// Depends on tpar_pkg.
module tpar_front import tpar_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic signed [QW-1:0] i_q [4],
    input  logic signed [QW-1:0] i_g [4],
    output logic                 o_vld,
    output logic [D2W-1:0]       o_d2,
    output t_raw                 o_raw
);

    logic signed [2*QW-1:0] r_p [16];
    logic                   r_v1, r_v2, r_v3, r_v4;
    logic signed [EW-1:0]   r_ew, r_ex, r_ey, r_ez;
    logic signed [2*EW-1:0] r_sqw, r_sqz, r_wx, r_yz, r_wy, r_xz;
    logic signed [EW-1:0]   r_ez3;
    logic                   r_ewle;
    logic [D2W-1:0]         r_d2;
    t_raw                   r_raw;

    logic signed [2*QW+1:0] n_sw, n_sx, n_sy, n_sz;
    logic signed [2*QW+1:0] n_tw, n_tx, n_ty, n_tz;
    logic signed [2*EW:0]   n_rx, n_ry;
    logic [EW-1:0]          n_az;
    t_raw                   n_raw;

    // Products are ordered so that each error component takes four neighbors.
    always_ff @(posedge i_clk) begin
        r_p[0]  <= i_q[0] * i_g[0];
        r_p[1]  <= i_q[1] * i_g[1];
        r_p[2]  <= i_q[2] * i_g[2];
        r_p[3]  <= i_q[3] * i_g[3];
        r_p[4]  <= i_q[0] * i_g[1];
        r_p[5]  <= i_g[0] * i_q[1];
        r_p[6]  <= i_q[2] * i_g[3];
        r_p[7]  <= i_q[3] * i_g[2];
        r_p[8]  <= i_q[0] * i_g[2];
        r_p[9]  <= i_g[0] * i_q[2];
        r_p[10] <= i_q[3] * i_g[1];
        r_p[11] <= i_q[1] * i_g[3];
        r_p[12] <= i_q[0] * i_g[3];
        r_p[13] <= i_g[0] * i_q[3];
        r_p[14] <= i_q[1] * i_g[2];
        r_p[15] <= i_q[2] * i_g[1];
    end

    always_comb begin
        n_sw = 34'(r_p[0]) + 34'(r_p[1]) + 34'(r_p[2]) + 34'(r_p[3]);
        n_sx = 34'(r_p[4]) - 34'(r_p[5]) - 34'(r_p[6]) + 34'(r_p[7]);
        n_sy = 34'(r_p[8]) - 34'(r_p[9]) - 34'(r_p[10]) + 34'(r_p[11]);
        n_sz = 34'(r_p[12]) - 34'(r_p[13]) - 34'(r_p[14]) + 34'(r_p[15]);
        // Round half up to Q.14: add one half, then floor by arithmetic shift.
        n_tw = n_sw + 34'sd8192;
        n_tx = n_sx + 34'sd8192;
        n_ty = n_sy + 34'sd8192;
        n_tz = n_sz + 34'sd8192;
    end

    always_ff @(posedge i_clk) begin
        r_ew <= n_tw[33:14];
        r_ex <= n_tx[33:14];
        r_ey <= n_ty[33:14];
        r_ez <= n_tz[33:14];
    end

    always_ff @(posedge i_clk) begin
        r_sqw  <= r_ew * r_ew;
        r_sqz  <= r_ez * r_ez;
        r_wx   <= r_ew * r_ex;
        r_yz   <= r_ey * r_ez;
        r_wy   <= r_ew * r_ey;
        r_xz   <= r_ex * r_ez;
        r_ez3  <= r_ez;
        r_ewle <= (r_ew <= 0);
    end

    always_comb begin
        n_rx = 41'(r_wx) - 41'(r_yz);
        n_ry = 41'(r_wy) + 41'(r_xz);
        n_az = r_ez3[EW-1] ? EW'(-r_ez3) : EW'(r_ez3);
        n_raw.neg[0] = n_rx[2*EW];
        n_raw.neg[1] = n_ry[2*EW];
        n_raw.neg[2] = r_ez3[EW-1] ^ r_ewle;
        n_raw.mag_x  = n_rx[2*EW] ? MAGW'(-n_rx) : MAGW'(n_rx);
        n_raw.mag_y  = n_ry[2*EW] ? MAGW'(-n_ry) : MAGW'(n_ry);
        n_raw.mag_z  = {4'b0, n_az, 14'b0};
    end

    always_ff @(posedge i_clk) begin
        r_d2  <= D2W'(r_sqw) + D2W'(r_sqz);
        r_raw <= n_raw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    assign o_vld = r_v4;
    assign o_d2  = r_d2;
    assign o_raw = r_raw;

endmodule

>>> hw/rtl/tpar_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on tpar_pkg.
module tpar_sqrt import tpar_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  logic [D2W-1:0] i_rad,
    output logic           o_vld,
    output logic [DW-1:0]  o_root
);

    logic [D2W-1:0] r_rem  [DW+1];
    logic [DW-1:0]  r_root [DW+1];
    logic           r_vld  [DW+1];

    assign r_rem[0]  = i_rad;
    assign r_root[0] = '0;
    assign r_vld[0]  = i_vld;

    for (genvar k = 0; k < DW; k++) begin : g_stage
        localparam int B = DW - 1 - k;
        logic [D2W-1:0] trial;
        logic           take;

        // (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B)
        always_comb begin
            trial = (D2W'(r_root[k]) << (B + 1)) + (D2W'(1) << (2 * B));
            take  = (r_rem[k] >= trial);
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= take ? r_rem[k] - trial : r_rem[k];
            r_root[k+1] <= take ? (r_root[k] | (DW'(1) << B)) : r_root[k];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
        end
    end

    assign o_vld  = r_vld[DW];
    assign o_root = r_root[DW];

endmodule

>>> hw/rtl/tpar_div.sv
// Pipelined rounding divider with saturation for one rate lane.
// Depends on tpar_pkg.
module tpar_div import tpar_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  t_div_req       i_req,
    output logic           o_vld,
    output logic [RW-1:0]  o_rate
);

    localparam int NW = NUMW + 2;
    localparam int BW = DENW + 1;

    logic [NW-1:0]  r_rem  [RW+1];
    logic [RW-1:0]  r_q    [RW+1];
    logic [BW-1:0]  r_d    [RW+1];
    logic           r_neg  [RW+1];
    logic           r_zero [RW+1];
    logic           r_ovf  [RW+1];
    logic           r_vld  [RW+1];
    logic [RW-1:0]  r_rate;
    logic           r_ovld;

    logic [NW-1:0]  n_n;
    logic [BW-1:0]  n_d;
    logic [RW-1:0]  n_rate;

    // Numerator 2*num + den over 2*den rounds half away from zero.
    always_comb begin
        n_n = {1'b0, i_req.num, 1'b0} + NW'(i_req.den);
        n_d = {i_req.den, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= n_n;
        r_d[0]    <= n_d;
        r_q[0]    <= '0;
        r_neg[0]  <= i_req.neg;
        r_zero[0] <= i_req.zero;
        r_ovf[0]  <= (n_n >= (NW'(n_d) << RW));
    end

    for (genvar k = 0; k < RW; k++) begin : g_stage
        localparam int B = RW - 1 - k;
        logic [NW-1:0] sh;
        logic          take;

        always_comb begin
            sh   = NW'(r_d[k]) << B;
            take = (r_rem[k] >= sh);
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= take ? r_rem[k] - sh : r_rem[k];
            r_q[k+1]    <= take ? (r_q[k] | (RW'(1) << B)) : r_q[k];
            r_d[k+1]    <= r_d[k];
            r_neg[k+1]  <= r_neg[k];
            r_zero[k+1] <= r_zero[k];
            r_ovf[k+1]  <= r_ovf[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    for (genvar k = 0; k < RW; k++) begin : g_vld
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
        end
    end

    always_comb begin
        if (r_zero[RW]) begin
            n_rate = '0;
        end else if (r_neg[RW]) begin
            if (r_ovf[RW] || (r_q[RW] > {1'b1, {(RW-1){1'b0}}})) begin
                n_rate = {1'b1, {(RW-1){1'b0}}};
            end else begin
                n_rate = RW'(-r_q[RW]);
            end
        end else begin
            if (r_ovf[RW] || r_q[RW][RW-1]) begin
                n_rate = {1'b0, {(RW-1){1'b1}}};
            end else begin
                n_rate = r_q[RW];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rate <= n_rate;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= r_vld[RW];
        end
    end

    assign o_vld  = r_ovld;
    assign o_rate = r_rate;

endmodule

>>> hw/rtl/tpar_checker.sv
// Port-level checker of the attitude rate block and its bind to the top level.
// Depends on tpar_pkg and tilt_prioritized_attitude_rates_top_macros.svh.
`include "tilt_prioritized_attitude_rates_top_macros.svh"

module tpar_checker import tpar_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_valid,
    input logic signed [RW-1:0] o_rate_roll,
    input logic signed [RW-1:0] o_rate_pitch,
    input logic signed [RW-1:0] o_rate_yaw,
    input logic                 o_undefined_flag
);

    logic [5:0] r_age;
    logic       warm;

    // Cycles since reset, so that beats dropped by reset are not expected.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age <= '0;
        end else if (r_age != 6'd63) begin
            r_age <= r_age + 6'd1;
        end
    end

    assign warm = (r_age > 6'(LATENCY));

    `TPAR_ASSERT_IMP(a_latency, i_clk, i_rst_n, warm,
        o_valid == $past(start && !busy, LATENCY))
    `TPAR_ASSERT_IMP(a_flag_zero, i_clk, i_rst_n, o_undefined_flag,
        (o_rate_roll == '0) && (o_rate_pitch == '0) && (o_rate_yaw == '0))
    `TPAR_ASSERT_IMP(a_flag_strobe, i_clk, i_rst_n, !o_valid, !o_undefined_flag)
    `TPAR_ASSERT_IMP(a_busy_drop, i_clk, i_rst_n, $past(i_rst_n), !busy)

endmodule

bind tilt_prioritized_attitude_rates_top tpar_checker u_tpar_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_valid          (o_valid),
    .o_rate_roll      (o_rate_roll),
    .o_rate_pitch     (o_rate_pitch),
    .o_rate_yaw       (o_rate_yaw),
    .o_undefined_flag (o_undefined_flag)
);
